@@ rtl/c2p_pkg.sv @@
// c2p_pkg: shared constants, control struct and arctangent table for the
// cartesian to polar converter. No dependencies.
package c2p_pkg;

    // cordic vector and angle accumulator widths, scaling and rounding shifts, table length and output word width
    localparam int VEC_W     = 62;
    localparam int ZACC_W    = 34;
    localparam int SCALE_EXP = 60;
    localparam int ZROUND_SH = 17;
    localparam int ATAN_LEN  = 24;
    localparam int OUT_W     = 32;

    localparam logic signed [ZACC_W-1:0] PI_Q30      = 34'sd3373259426;
    localparam logic signed [15:0]       PI_Q13      = 16'sd25736;
    localparam logic signed [15:0]       HALF_PI_Q13 = 16'sd12868;

    // control bits that travel with each word
    typedef struct packed {
        logic valid;
        logic x_neg;
        logic y_neg;
        logic x_zero;
        logic y_zero;
    } t_ctl;

    // atan(2^-i) in q30, truncated
    function automatic logic [29:0] atan_q30(input logic [4:0] idx);
        logic [29:0] v;
        case (idx)
            5'd0:  v = 30'd843314856;
            5'd1:  v = 30'd497837829;
            5'd2:  v = 30'd263043836;
            5'd3:  v = 30'd133525158;
            5'd4:  v = 30'd67021686;
            5'd5:  v = 30'd33543515;
            5'd6:  v = 30'd16775850;
            5'd7:  v = 30'd8388437;
            5'd8:  v = 30'd4194282;
            5'd9:  v = 30'd2097149;
            5'd10: v = 30'd1048575;
            5'd11: v = 30'd524287;
            5'd12: v = 30'd262143;
            5'd13: v = 30'd131071;
            5'd14: v = 30'd65535;
            5'd15: v = 30'd32767;
            5'd16: v = 30'd16383;
            5'd17: v = 30'd8191;
            5'd18: v = 30'd4095;
            5'd19: v = 30'd2047;
            5'd20: v = 30'd1023;
            5'd21: v = 30'd511;
            5'd22: v = 30'd255;
            5'd23: v = 30'd127;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/c2p_stage.sv @@
// c2p_stage: one pipeline stage, up to one square root bit and one cordic
// micro-rotation, registered with a shared advance enable. Uses c2p_pkg.
module c2p_stage #(
    parameter int COORD_WIDTH  = 16,
    parameter int CORDIC_STEPS = 16,
    parameter int STEP         = 0
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_en,
    input  c2p_pkg::t_ctl                           i_ctl,
    input  logic [2*COORD_WIDTH:0]                  i_rem,
    input  logic [COORD_WIDTH-1:0]                  i_root,
    input  logic signed [c2p_pkg::VEC_W-1:0]        i_vx,
    input  logic signed [c2p_pkg::VEC_W-1:0]        i_vy,
    input  logic signed [c2p_pkg::ZACC_W-1:0]       i_z,
    output c2p_pkg::t_ctl                           o_ctl,
    output logic [2*COORD_WIDTH:0]                  o_rem,
    output logic [COORD_WIDTH-1:0]                  o_root,
    output logic signed [c2p_pkg::VEC_W-1:0]        o_vx,
    output logic signed [c2p_pkg::VEC_W-1:0]        o_vy,
    output logic signed [c2p_pkg::ZACC_W-1:0]       o_z
);

    localparam int NW = 2 * COORD_WIDTH + 1;
    localparam int VW = c2p_pkg::VEC_W;
    localparam int ZW = c2p_pkg::ZACC_W;

    logic [NW-1:0]          n_rem;
    logic [COORD_WIDTH-1:0] n_root;
    logic signed [VW-1:0]   n_vx;
    logic signed [VW-1:0]   n_vy;
    logic signed [ZW-1:0]   n_z;

    c2p_pkg::t_ctl          r_ctl;
    logic [NW-1:0]          r_rem;
    logic [COORD_WIDTH-1:0] r_root;
    logic signed [VW-1:0]   r_vx;
    logic signed [VW-1:0]   r_vy;
    logic signed [ZW-1:0]   r_z;

    // restoring square root: decide root bit B
    generate
        if (STEP < COORD_WIDTH) begin : g_sqrt
            localparam int B = COORD_WIDTH - 1 - STEP;
            logic [NW-1:0] w_trial;
            // trial = 2^B * (2*root + 2^B)
            assign w_trial = ({{(NW-COORD_WIDTH-1){1'b0}}, i_root, 1'b0}
                              + (NW'(1) << B)) << B;
            always_comb begin
                if (i_rem >= w_trial) begin
                    n_rem  = i_rem - w_trial;
                    n_root = i_root | (COORD_WIDTH'(1) << B);
                end else begin
                    n_rem  = i_rem;
                    n_root = i_root;
                end
            end
        end else begin : g_sqrt_pass
            assign n_rem  = i_rem;
            assign n_root = i_root;
        end
    endgenerate

    // cordic vectoring micro-rotation toward the x axis
    generate
        if (STEP < CORDIC_STEPS) begin : g_rot
            logic signed [VW-1:0] w_dx;
            logic signed [VW-1:0] w_dy;
            logic signed [ZW-1:0] w_atan;
            logic                 w_neg;
            assign w_dx   = i_vy >>> STEP;
            assign w_dy   = i_vx >>> STEP;
            assign w_atan = $signed(ZW'(c2p_pkg::atan_q30(5'(STEP))));
            assign w_neg  = i_vy[VW-1];
            always_comb begin
                if (w_neg) begin
                    n_vx = i_vx - w_dx;
                    n_vy = i_vy + w_dy;
                    n_z  = i_z - w_atan;
                end else begin
                    n_vx = i_vx + w_dx;
                    n_vy = i_vy - w_dy;
                    n_z  = i_z + w_atan;
                end
            end
        end else begin : g_rot_pass
            assign n_vx = i_vx;
            assign n_vy = i_vy;
            assign n_z  = i_z;
        end
    endgenerate

    // control bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_root <= n_root;
            r_vx   <= n_vx;
            r_vy   <= n_vy;
            r_z    <= n_z;
        end
    end

    assign o_ctl  = r_ctl;
    assign o_rem  = r_rem;
    assign o_root = r_root;
    assign o_vx   = r_vx;
    assign o_vy   = r_vy;
    assign o_z    = r_z;

endmodule

@@ rtl/c2p_out_fifo.sv @@
// c2p_out_fifo: two-entry output queue that decouples the pipeline advance
// from the consumer's ready. Uses c2p_pkg for the word width.
module c2p_out_fifo (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  logic [c2p_pkg::OUT_W-1:0]     i_data,
    input  logic                          i_ready,
    output logic                          o_full,
    output logic                          o_valid,
    output logic [c2p_pkg::OUT_W-1:0]     o_data
);

    logic [c2p_pkg::OUT_W-1:0] r_mem [2];
    logic                      r_wr_ptr;
    logic                      r_rd_ptr;
    logic [1:0]                r_count;
    logic [1:0]                n_count;
    logic                      w_pop;

    assign w_pop   = (r_count != 2'd0) && i_ready;
    assign o_valid = (r_count != 2'd0);
    assign o_full  = (r_count == 2'd2);
    assign o_data  = r_mem[r_rd_ptr];

    // occupancy
    always_comb begin
        n_count = r_count;
        if (i_push && !w_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && w_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    // pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

@@ rtl/cartesian_to_polar_top.sv @@
// input words pass the front stages (capture, square, sum), the iteration stages and the
// output queue; throughput one word per cycle while the output queue has room
// each iteration stage resolves up to one root bit and one micro-rotation, so the
// stage count follows the wider of the coordinate width and the rotation count
// reset (synchronous, active low) clears stage valid bits and the output queue
module cartesian_to_polar_top #(
    parameter int CORDIC_STEPS = 16,
    parameter int COORD_WIDTH  = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [COORD_WIDTH-1:0] i_x_coord,
    input  logic signed [COORD_WIDTH-1:0] i_y_coord,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [15:0]                   o_magnitude,
    output logic signed [15:0]            o_angle
);

    localparam int W      = COORD_WIDTH;
    localparam int NS     = (W > CORDIC_STEPS) ? W : CORDIC_STEPS;
    localparam int NW     = 2 * W + 1;
    localparam int SQW    = 2 * W;
    localparam int VW     = c2p_pkg::VEC_W;
    localparam int ZW     = c2p_pkg::ZACC_W;
    localparam int PRE_SH = c2p_pkg::SCALE_EXP - W;
    localparam int MW     = (W + 1 > 17) ? W + 1 : 17;

    logic w_en;
    logic w_full;

    // input decode
    c2p_pkg::t_ctl        w_ctl_in;
    logic [W-1:0]         w_ax;
    logic [W-1:0]         w_ay;
    logic signed [VW-1:0] w_xs;
    logic signed [VW-1:0] w_ys;
    logic signed [VW-1:0] w_vx0;
    logic signed [VW-1:0] w_vy0;
    logic signed [ZW-1:0] w_z0;

    // front stages
    c2p_pkg::t_ctl        r1_ctl, r2_ctl, r3_ctl;
    logic [W-1:0]         r1_ax, r1_ay;
    logic [SQW-1:0]       r2_sqx, r2_sqy;
    logic [NW-1:0]        r3_n;
    logic signed [VW-1:0] r1_vx, r1_vy, r2_vx, r2_vy, r3_vx, r3_vy;
    logic signed [ZW-1:0] r1_z, r2_z, r3_z;

    // iteration chain
    c2p_pkg::t_ctl        w_ctl  [NS+1];
    logic [NW-1:0]        w_rem  [NS+1];
    logic [W-1:0]         w_root [NS+1];
    logic signed [VW-1:0] w_vx   [NS+1];
    logic signed [VW-1:0] w_vy   [NS+1];
    logic signed [ZW-1:0] w_z    [NS+1];

    // finishing
    logic                 w_rnd;
    logic [MW-1:0]        w_mag_ext;
    logic [15:0]          w_mag;
    logic signed [ZW-1:0] w_zsum;
    logic signed [ZW-1:0] w_zr;
    logic signed [ZW-1:0] w_pi_ext;
    logic signed [15:0]   w_cord_ang;
    logic signed [15:0]   w_ang;
    logic [c2p_pkg::OUT_W-1:0] w_out_data;

    // pipeline advances whenever the output queue has room
    assign w_en    = !w_full;
    assign o_ready = w_en;

    // absolute values, half-plane fold and special-case flags
    assign w_ax = i_x_coord[W-1] ? W'(-i_x_coord) : W'(i_x_coord);
    assign w_ay = i_y_coord[W-1] ? W'(-i_y_coord) : W'(i_y_coord);
    assign w_xs = VW'(i_x_coord);
    assign w_ys = VW'(i_y_coord);

    always_comb begin
        w_ctl_in.valid  = i_valid;
        w_ctl_in.x_neg  = i_x_coord[W-1];
        w_ctl_in.y_neg  = i_y_coord[W-1];
        w_ctl_in.x_zero = (i_x_coord == '0);
        w_ctl_in.y_zero = (i_y_coord == '0);
        if (i_x_coord[W-1]) begin
            w_vx0 = (-w_xs) <<< PRE_SH;
            w_vy0 = (-w_ys) <<< PRE_SH;
            w_z0  = i_y_coord[W-1] ? -c2p_pkg::PI_Q30 : c2p_pkg::PI_Q30;
        end else begin
            w_vx0 = w_xs <<< PRE_SH;
            w_vy0 = w_ys <<< PRE_SH;
            w_z0  = '0;
        end
    end

    // front stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_ctl <= '0;
            r2_ctl <= '0;
            r3_ctl <= '0;
        end else if (w_en) begin
            r1_ctl <= w_ctl_in;
            r2_ctl <= r1_ctl;
            r3_ctl <= r2_ctl;
        end
    end

    // front stage data: capture, square, sum
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_ax  <= w_ax;
            r1_ay  <= w_ay;
            r1_vx  <= w_vx0;
            r1_vy  <= w_vy0;
            r1_z   <= w_z0;
            r2_sqx <= SQW'(r1_ax) * SQW'(r1_ax);
            r2_sqy <= SQW'(r1_ay) * SQW'(r1_ay);
            r2_vx  <= r1_vx;
            r2_vy  <= r1_vy;
            r2_z   <= r1_z;
            r3_n   <= NW'(r2_sqx) + NW'(r2_sqy);
            r3_vx  <= r2_vx;
            r3_vy  <= r2_vy;
            r3_z   <= r2_z;
        end
    end

    assign w_ctl[0]  = r3_ctl;
    assign w_rem[0]  = r3_n;
    assign w_root[0] = '0;
    assign w_vx[0]   = r3_vx;
    assign w_vy[0]   = r3_vy;
    assign w_z[0]    = r3_z;

    // iteration stages
    generate
        for (genvar k = 0; k < NS; k++) begin : g_stage
            c2p_stage #(
                .COORD_WIDTH  (COORD_WIDTH),
                .CORDIC_STEPS (CORDIC_STEPS),
                .STEP         (k)
            ) u_stage (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (w_en),
                .i_ctl   (w_ctl[k]),
                .i_rem   (w_rem[k]),
                .i_root  (w_root[k]),
                .i_vx    (w_vx[k]),
                .i_vy    (w_vy[k]),
                .i_z     (w_z[k]),
                .o_ctl   (w_ctl[k+1]),
                .o_rem   (w_rem[k+1]),
                .o_root  (w_root[k+1]),
                .o_vx    (w_vx[k+1]),
                .o_vy    (w_vy[k+1]),
                .o_z     (w_z[k+1])
            );
        end
    endgenerate

    // magnitude: round to nearest, saturate to 16 bits
    assign w_rnd     = (w_rem[NS] > NW'(w_root[NS]));
    assign w_mag_ext = MW'(w_root[NS]) + MW'(w_rnd);
    assign w_mag     = (|w_mag_ext[MW-1:16]) ? 16'hFFFF : w_mag_ext[15:0];

    // angle: q30 to q13 round half up, clamp to +-pi
    assign w_zsum   = w_z[NS] + $signed(ZW'(1) << (c2p_pkg::ZROUND_SH - 1));
    assign w_zr     = w_zsum >>> c2p_pkg::ZROUND_SH;
    assign w_pi_ext = ZW'(c2p_pkg::PI_Q13);

    always_comb begin
        if (w_zr > w_pi_ext) begin
            w_cord_ang = c2p_pkg::PI_Q13;
        end else if (w_zr < -w_pi_ext) begin
            w_cord_ang = -c2p_pkg::PI_Q13;
        end else begin
            w_cord_ang = w_zr[15:0];
        end
    end

    // axis cases override the rotation result
    always_comb begin
        if (w_ctl[NS].y_zero) begin
            w_ang = w_ctl[NS].x_neg ? c2p_pkg::PI_Q13 : '0;
        end else if (w_ctl[NS].x_zero) begin
            w_ang = w_ctl[NS].y_neg ? -c2p_pkg::HALF_PI_Q13 : c2p_pkg::HALF_PI_Q13;
        end else begin
            w_ang = w_cord_ang;
        end
    end

    // output queue
    c2p_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_en && w_ctl[NS].valid),
        .i_data  ({w_mag, w_ang}),
        .i_ready (i_ready),
        .o_full  (w_full),
        .o_valid (o_valid),
        .o_data  (w_out_data)
    );

    assign o_magnitude = w_out_data[31:16];
    assign o_angle     = w_out_data[15:0];

endmodule

@@ rtl/c2p_checker.sv @@
// c2p_checker: port-level assertions for cartesian_to_polar_top, attached
// by the bind at the end of this file. No package dependencies.
module c2p_checker #(
    parameter int CORDIC_STEPS = 16,
    parameter int COORD_WIDTH  = 16
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_ready,
    input logic               o_valid,
    input logic               i_ready,
    input logic [15:0]        o_magnitude,
    input logic signed [15:0] o_angle
);

    localparam int NS   = (COORD_WIDTH > CORDIC_STEPS) ? COORD_WIDTH : CORDIC_STEPS;
    localparam int MAXO = NS + 8;
    localparam int CW   = $clog2(MAXO + 1);

    logic [CW-1:0] r_cnt;
    logic          w_in_acc;
    logic          w_out_acc;

    assign w_in_acc  = i_valid && o_ready;
    assign w_out_acc = o_valid && i_ready;

    // words inside the block
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (w_in_acc && !w_out_acc) begin
            r_cnt <= r_cnt + CW'(1);
        end else if (!w_in_acc && w_out_acc) begin
            r_cnt <= r_cnt - CW'(1);
        end
    end

    // a held result word stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_magnitude) && $stable(o_angle))
        else $error("output word changed while stalled");

    // no result without an accepted input
    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_cnt != '0)
        else $error("output word without pending input");

    // angle stays within +-pi
    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_angle <= 16'sd25736) && (o_angle >= -16'sd25736))
        else $error("angle out of range");

    // reset empties the block
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid)
        else $error("output valid right after reset");

endmodule

bind cartesian_to_polar_top c2p_checker #(
    .CORDIC_STEPS (CORDIC_STEPS),
    .COORD_WIDTH  (COORD_WIDTH)
) u_c2p_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_ready     (o_ready),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_magnitude (o_magnitude),
    .o_angle     (o_angle)
);

@@ dv/tb_cartesian_to_polar_top.sv @@
// tb_cartesian_to_polar_top: self-checking testbench for the cartesian to polar converter
// drives points through the valid/ready input and checks magnitude and angle words
// depends on rtl/cartesian_to_polar_top.sv (and the c2p_pkg, c2p_stage and c2p_out_fifo it uses)
module tb_cartesian_to_polar_top;

    localparam int     STEPS        = 16;
    localparam int     CW           = 16;
    localparam int     PIPE_LAT     = 20;
    localparam int     RANDOM_ITEMS = 1700;
    localparam longint ANG_PI_Q30   = 64'sd3373259426;
    localparam int     ANG_PI_Q13   = 25736;
    localparam int     ANG_HPI_Q13  = 12868;

    typedef struct packed {
        logic [15:0]        magnitude;
        logic signed [15:0] angle;
    } t_polar_word;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_ready;
    logic signed [CW-1:0] i_x_coord;
    logic signed [CW-1:0] i_y_coord;
    logic                 o_valid;
    logic                 i_ready;
    logic [15:0]          o_magnitude;
    logic signed [15:0]   o_angle;

    t_polar_word expected_polar[$];
    int          error_count;
    int          send_gap_max;
    int          recv_gap_max;

    cartesian_to_polar_top #(
        .CORDIC_STEPS (STEPS),
        .COORD_WIDTH  (CW)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_x_coord   (i_x_coord),
        .i_y_coord   (i_y_coord),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_magnitude (o_magnitude),
        .o_angle     (o_angle)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

    // expected polar word for one point: rounded root and vectoring cordic angle
    function automatic t_polar_word polar_of(input logic signed [CW-1:0] x,
                                             input logic signed [CW-1:0] y);
        t_polar_word w;
        longint xs, ys, sq, root, bitv, rem;
        longint vx, vy, dx, dy, z, step_ang;
        xs = x;
        ys = y;
        sq = xs * xs + ys * ys;

        // bitwise integer square root, then round to nearest
        root = 0;
        rem  = sq;
        bitv = 64'sd1 <<< 62;
        while (bitv > rem) bitv = bitv >>> 2;
        while (bitv != 0) begin
            if (rem >= root + bitv) begin
                rem  = rem - (root + bitv);
                root = (root >>> 1) + bitv;
            end else begin
                root = root >>> 1;
            end
            bitv = bitv >>> 2;
        end
        if (sq - root * root > root) root = root + 1;
        if (root > 65535) root = 65535;
        w.magnitude = root[15:0];

        if (ys == 0) begin
            w.angle = (xs < 0) ? 16'(ANG_PI_Q13) : 16'sd0;
        end else if (xs == 0) begin
            w.angle = (ys > 0) ? 16'(ANG_HPI_Q13) : 16'(-ANG_HPI_Q13);
        end else begin
            // left half plane: turn by pi first
            z = 0;
            if (xs < 0) begin
                z  = (ys >= 0) ? ANG_PI_Q30 : -ANG_PI_Q30;
                xs = -xs;
                ys = -ys;
            end
            vx = xs * (64'sd1 <<< (60 - CW));
            vy = ys * (64'sd1 <<< (60 - CW));
            for (int i = 0; i < STEPS; i++) begin
                case (i)
                    0:       step_ang = 843314856;
                    1:       step_ang = 497837829;
                    2:       step_ang = 263043836;
                    3:       step_ang = 133525158;
                    4:       step_ang = 67021686;
                    5:       step_ang = 33543515;
                    6:       step_ang = 16775850;
                    7:       step_ang = 8388437;
                    8:       step_ang = 4194282;
                    9:       step_ang = 2097149;
                    10:      step_ang = 1048575;
                    11:      step_ang = 524287;
                    12:      step_ang = 262143;
                    13:      step_ang = 131071;
                    14:      step_ang = 65535;
                    default: step_ang = 32767;
                endcase
                dx = vy >>> i;
                dy = vx >>> i;
                if (vy >= 0) begin
                    vx = vx + dx;
                    vy = vy - dy;
                    z  = z + step_ang;
                end else begin
                    vx = vx - dx;
                    vy = vy + dy;
                    z  = z - step_ang;
                end
            end
            // q30 to q13, round half up, then clamp to +-pi
            z = (z + (64'sd1 <<< 16)) >>> 17;
            if (z > ANG_PI_Q13) z = ANG_PI_Q13;
            if (z < -ANG_PI_Q13) z = -ANG_PI_Q13;
            w.angle = z[15:0];
        end
        return w;
    endfunction

    // record accepted points and check each result word against the oldest expectation
    always @(posedge i_clk) begin
        t_polar_word want;
        if (i_rst_n) begin
            if (i_valid && o_ready) expected_polar.push_back(polar_of(i_x_coord, i_y_coord));
            if (o_valid && i_ready) begin
                if (expected_polar.size() == 0) begin
                    error_count++;
                    if (error_count <= 10)
                        $display("mismatch: unexpected word mag=%0d ang=%0d",
                                 o_magnitude, o_angle);
                end else begin
                    want = expected_polar.pop_front();
                    if (o_magnitude !== want.magnitude || o_angle !== want.angle) begin
                        error_count++;
                        if (error_count <= 10)
                            $display("mismatch: mag exp %0d got %0d, ang exp %0d got %0d",
                                     want.magnitude, o_magnitude, want.angle, o_angle);
                    end
                end
            end
        end
    end

    // output side: random stall before taking each word
    initial begin
        int stall;
        i_ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            stall = $urandom_range(0, recv_gap_max);
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    // send one point, holding it until the block takes the word
    task automatic send_point(input logic signed [CW-1:0] x, input logic signed [CW-1:0] y);
        int gap;
        gap = $urandom_range(0, send_gap_max);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_x_coord <= x;
        i_y_coord <= y;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // origin and the four half axes
    task automatic test_axis_cases();
        send_point(16'sd0, 16'sd0);
        send_point(16'sd1, 16'sd0);
        send_point(16'sd32767, 16'sd0);
        send_point(-16'sd1, 16'sd0);
        send_point(-16'sd32768, 16'sd0);
        send_point(16'sd0, 16'sd1);
        send_point(16'sd0, -16'sd1);
        send_point(16'sd0, 16'sd32767);
        send_point(16'sd0, -16'sd32768);
    endtask

    // all quadrants, corners of the range and points near the pi cut
    task automatic test_quadrants_and_extremes();
        send_point(16'sd1, 16'sd1);
        send_point(-16'sd1, 16'sd1);
        send_point(-16'sd1, -16'sd1);
        send_point(16'sd1, -16'sd1);
        send_point(-16'sd32768, -16'sd32768);
        send_point(16'sd32767, 16'sd32767);
        send_point(-16'sd32768, 16'sd32767);
        send_point(16'sd32767, -16'sd32768);
        send_point(-16'sd32768, 16'sd1);
        send_point(-16'sd32768, -16'sd1);
        send_point(-16'sd1, 16'sd32767);
        send_point(-16'sd1, -16'sd32768);
        send_point(16'sd3, 16'sd4);
        send_point(-16'sd5, -16'sd12);
        send_point(16'sh5555, -16'sh2aab);
    endtask

    // random points in segments, each segment with its own idling pattern
    task automatic test_random_points(input int count);
        logic signed [CW-1:0] x, y;
        int kind;
        for (int n = 0; n < count; n++) begin
            if (n % 50 == 0) begin
                case ($urandom_range(0, 3))
                    0: begin send_gap_max = 11; recv_gap_max = 11; end
                    1: begin send_gap_max = 0;  recv_gap_max = 11; end
                    2: begin send_gap_max = 11; recv_gap_max = 0;  end
                    default: begin send_gap_max = 0; recv_gap_max = 0; end
                endcase
            end
            kind = $urandom_range(0, 99);
            x = CW'($urandom);
            y = CW'($urandom);
            if (kind >= 60 && kind < 75) begin
                // tiny vectors close to the origin
                x = CW'($signed($urandom_range(0, 16)) - 8);
                y = CW'($signed($urandom_range(0, 16)) - 8);
            end else if (kind >= 75 && kind < 85) begin
                // one coordinate on an axis
                if ($urandom_range(0, 1)) x = '0;
                else y = '0;
            end else if (kind >= 85 && kind < 95) begin
                // coordinates at the ends of the range
                if ($urandom_range(0, 1)) x = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
                if ($urandom_range(0, 1)) y = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            end else if (kind >= 95) begin
                // one small coordinate against a large one
                if ($urandom_range(0, 1)) x = CW'($signed($urandom_range(0, 6)) - 3);
                else y = CW'($signed($urandom_range(0, 6)) - 3);
            end
            send_point(x, y);
        end
    endtask

    // reset, tests in turn, drain and verdict
    initial begin
        error_count  = 0;
        send_gap_max = 11;
        recv_gap_max = 11;
        i_rst_n   <= 1'b0;
        i_valid   <= 1'b0;
        i_x_coord <= '0;
        i_y_coord <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_axis_cases();
        test_quadrants_and_extremes();
        test_random_points(RANDOM_ITEMS);
        i_valid <= 1'b0;

        send_gap_max = 11;
        recv_gap_max = 11;
        while (expected_polar.size() != 0) @(posedge i_clk);
        repeat (PIPE_LAT + 10) @(posedge i_clk);

        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/c2p_pkg.sv
rtl/c2p_stage.sv
rtl/c2p_out_fifo.sv
rtl/cartesian_to_polar_top.sv
rtl/c2p_checker.sv
dv/tb_cartesian_to_polar_top.sv
